// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W       = 16;
  localparam int CH_W        = 8;
  localparam int SECTOR_SIZE = 256;
  localparam int HUE_LIMIT   = 1536;

  localparam int POS_W  = $clog2(SECTOR_SIZE);
  localparam int PROD_W = CH_W + POS_W;

  // floor(2^W / SECTOR_SIZE): quotient estimate is exact or one low
  localparam logic [HUE_W-1:0]  HUE_RECIP  = HUE_W'((2 ** HUE_W) / SECTOR_SIZE);
  localparam logic [PROD_W-1:0] PROD_RECIP = PROD_W'((2 ** PROD_W) / SECTOR_SIZE);

  localparam logic [HUE_W-1:0]  SECTOR_HUE  = HUE_W'(SECTOR_SIZE);
  localparam logic [PROD_W-1:0] SECTOR_PROD = PROD_W'(SECTOR_SIZE);
  localparam logic [HUE_W-1:0]  HUE_LIMIT_L = HUE_W'(HUE_LIMIT);
  localparam logic [CH_W-1:0]   CH_MAX      = {CH_W{1'b1}};

  localparam int ORD_W = 3;
  localparam logic [ORD_W-1:0] ORD_RISE_G = 3'd0;
  localparam logic [ORD_W-1:0] ORD_FALL_R = 3'd1;
  localparam logic [ORD_W-1:0] ORD_RISE_B = 3'd2;
  localparam logic [ORD_W-1:0] ORD_FALL_G = 3'd3;
  localparam logic [ORD_W-1:0] ORD_RISE_R = 3'd4;
  localparam logic [ORD_W-1:0] ORD_FALL_B = 3'd5;

  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [ORD_W-1:0] ord;
  } ctrl_t;

endpackage

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-sector integer HSV to RGB conversion, one item per clock.
// ----------------------------------------------------------------------------
// An accepted item passes the registers c1_q to c5_q and the output register of hsv2rgb_mux before valid_o rises.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Depth is set by the two constant dividers (reciprocal multiply, then
// multiply-back correction), the ramp product and the output routing stage.
// Reset clears the control words (valid, gray, ord) and the output valid only; the receiver cannot stall.
module hsv_to_rgb_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]  brightness_i,
  output logic                         valid_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  blue_o
);
  import hsv2rgb_pkg::*;

  ctrl_t c1_q, c2_q, c3_q, c4_q, c5_q;
  ctrl_t c1_d, c2_d;

  // stage 1: hue clip, sector estimate, lowest level
  logic [HUE_W-1:0]   hue_c;
  logic [2*HUE_W-1:0] hq_prod;
  logic [2*CH_W-1:0]  lo_prod;
  logic [HUE_W-1:0]   hue1_q, q1_q;
  logic [CH_W-1:0]    lo1_q, v1_q;

  assign busy    = 1'b0;
  assign hue_c   = (hue_i >= HUE_LIMIT_L) ? '0 : hue_i;
  assign hq_prod = hue_c * HUE_RECIP;
  assign lo_prod = (CH_MAX - saturation_i) * brightness_i;

  always_comb begin
    c1_d       = '0;
    c1_d.valid = start & ~busy;
    c1_d.gray  = (saturation_i == '0);
  end

  // stage 2: sector correction, ordering, position
  logic [2*HUE_W-1:0] qd_prod;
  logic [HUE_W-1:0]   rem_h, sector, pos_full;
  logic               fix_h;
  logic [POS_W-1:0]   pos2_q;
  logic [CH_W-1:0]    diff2_q, lo2_q, v2_q;

  assign qd_prod  = q1_q * SECTOR_HUE;
  assign rem_h    = hue1_q - qd_prod[HUE_W-1:0];
  assign fix_h    = (rem_h >= SECTOR_HUE);
  assign sector   = q1_q + HUE_W'(fix_h);
  assign pos_full = fix_h ? (rem_h - SECTOR_HUE) : rem_h;

  always_comb begin
    c2_d     = c1_q;
    c2_d.ord = (sector > HUE_W'(ORD_FALL_B)) ? ORD_FALL_B : sector[ORD_W-1:0];
  end

  // stage 3: ramp product
  logic [PROD_W-1:0] x_prod, x3_q;
  logic [CH_W-1:0]   lo3_q, v3_q;

  assign x_prod = PROD_W'(diff2_q) * PROD_W'(pos2_q);

  // stage 4: ramp estimate
  logic [2*PROD_W-1:0] t_prod;
  logic [PROD_W-1:0]   x4_q;
  logic [CH_W-1:0]     t4_q, lo4_q, v4_q;

  assign t_prod = x3_q * PROD_RECIP;

  // stage 5: ramp correction
  logic [2*PROD_W-1:0] td_prod;
  logic [PROD_W-1:0]   rem_x;
  logic [CH_W-1:0]     ramp5_q, lo5_q, v5_q;

  assign td_prod = PROD_W'(t4_q) * SECTOR_PROD;
  assign rem_x   = x4_q - td_prod[PROD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else begin
      c1_q <= c1_d;
      c2_q <= c2_d;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hue1_q  <= hue_c;
    q1_q    <= hq_prod[2*HUE_W-1:HUE_W];
    lo1_q   <= lo_prod[2*CH_W-1:CH_W];
    v1_q    <= brightness_i;

    pos2_q  <= pos_full[POS_W-1:0];
    diff2_q <= v1_q - lo1_q;
    lo2_q   <= lo1_q;
    v2_q    <= v1_q;

    x3_q    <= x_prod;
    lo3_q   <= lo2_q;
    v3_q    <= v2_q;

    x4_q    <= x3_q;
    t4_q    <= t_prod[PROD_W+CH_W-1:PROD_W];
    lo4_q   <= lo3_q;
    v4_q    <= v3_q;

    ramp5_q <= t4_q + CH_W'(rem_x >= SECTOR_PROD);
    lo5_q   <= lo4_q;
    v5_q    <= v4_q;
  end

  hsv2rgb_mux u_mux (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (c5_q),
    .v_i     (v5_q),
    .lo_i    (lo5_q),
    .ramp_i  (ramp5_q),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule

// ----- rtl/hsv2rgb_mux.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_mux
// Output stage: forms rising and falling levels and routes them per sector, or v_i to all three for a gray item.
// ----------------------------------------------------------------------------
module hsv2rgb_mux (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hsv2rgb_pkg::ctrl_t        ctrl_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0] v_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0] lo_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0] ramp_i,
  output logic                      valid_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] blue_o
);
  import hsv2rgb_pkg::*;

  logic [CH_W-1:0] up, down;
  logic [CH_W-1:0] red_d, green_d, blue_d;
  logic [CH_W-1:0] red_q, green_q, blue_q;
  logic            valid_q;

  assign up   = lo_i + ramp_i;
  assign down = v_i - ramp_i;

  always_comb begin
    if (ctrl_i.gray) begin
      red_d = v_i; green_d = v_i; blue_d = v_i;
    end else begin
      case (ctrl_i.ord)
        ORD_RISE_G: begin red_d = v_i;  green_d = up;   blue_d = lo_i; end
        ORD_FALL_R: begin red_d = down; green_d = v_i;  blue_d = lo_i; end
        ORD_RISE_B: begin red_d = lo_i; green_d = v_i;  blue_d = up;   end
        ORD_FALL_G: begin red_d = lo_i; green_d = down; blue_d = v_i;  end
        ORD_RISE_R: begin red_d = up;   green_d = lo_i; blue_d = v_i;  end
        default:    begin red_d = v_i;  green_d = lo_i; blue_d = down; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ----- rtl/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input logic [hsv2rgb_pkg::CH_W-1:0]  saturation_i,
  input logic [hsv2rgb_pkg::CH_W-1:0]  brightness_i,
  input logic                         valid_o,
  input logic [hsv2rgb_pkg::CH_W-1:0]  red_o,
  input logic [hsv2rgb_pkg::CH_W-1:0]  green_o,
  input logic [hsv2rgb_pkg::CH_W-1:0]  blue_o
);
  import hsv2rgb_pkg::*;

  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 valid_o)
    else $error("accepted item produced no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##6 !valid_o)
    else $error("result without an accepted item");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(saturation_i, 6) == '0) |->
      (red_o == $past(brightness_i, 6) && green_o == $past(brightness_i, 6) &&
       blue_o == $past(brightness_i, 6)))
    else $error("zero saturation did not give gray");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((red_o == $past(brightness_i, 6) || green_o == $past(brightness_i, 6) ||
                  blue_o == $past(brightness_i, 6)) &&
                 red_o <= $past(brightness_i, 6) && green_o <= $past(brightness_i, 6) &&
                 blue_o <= $past(brightness_i, 6)))
    else $error("channel levels inconsistent with brightness");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .hue_i        (hue_i),
  .saturation_i (saturation_i),
  .brightness_i (brightness_i),
  .valid_o      (valid_o),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o)
);

// ----- verif/hsv_to_rgb_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking testbench for the six-sector HSV to RGB converter. A queue
// of HSV pixels (directed corner cases, then constrained-by-hand random
// pixels) feeds a clocked driver with random gaps; each accepted item is
// predicted in the testbench and the monitor compares every strobed RGB
// result, channel by channel, against the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  bri;
    bit               drain;
  } pixel_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  localparam int NUM_RANDOM = 1200;
  localparam int TAIL_CYCLES = 20;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic [HUE_W-1:0]  hue_i        = '0;
  logic [CH_W-1:0]   saturation_i = '0;
  logic [CH_W-1:0]   brightness_i = '0;
  logic              busy;
  logic              valid_o;
  logic [CH_W-1:0]   red_o;
  logic [CH_W-1:0]   green_o;
  logic [CH_W-1:0]   blue_o;

  pixel_t pixel_queue[$];
  rgb_t   rgb_expected[$];
  pixel_t cur_px;
  int     gap_cnt    = 0;
  bit     burst      = 1'b0;
  int     mismatches = 0;

  hsv_to_rgb_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rgb_t hsv_predict(input pixel_t px);
    int unsigned h, s, v, sector, pos, lo, ramp, up, down;
    rgb_t        c;
    h = px.hue;
    s = px.sat;
    v = px.bri;
    if (s == 0) begin
      c.red   = CH_W'(v);
      c.green = CH_W'(v);
      c.blue  = CH_W'(v);
      return c;
    end
    if (h >= HUE_LIMIT) h = 0;
    sector = h / SECTOR_SIZE;
    pos    = h % SECTOR_SIZE;
    lo     = ((CH_MAX - s) * v) / (1 << CH_W);
    ramp   = ((v - lo) * pos) / SECTOR_SIZE;
    up     = lo + ramp;
    down   = v - ramp;
    case (sector)
      ORD_RISE_G: begin c.red = CH_W'(v);    c.green = CH_W'(up);   c.blue = CH_W'(lo);   end
      ORD_FALL_R: begin c.red = CH_W'(down); c.green = CH_W'(v);    c.blue = CH_W'(lo);   end
      ORD_RISE_B: begin c.red = CH_W'(lo);   c.green = CH_W'(v);    c.blue = CH_W'(up);   end
      ORD_FALL_G: begin c.red = CH_W'(lo);   c.green = CH_W'(down); c.blue = CH_W'(v);    end
      ORD_RISE_R: begin c.red = CH_W'(up);   c.green = CH_W'(lo);   c.blue = CH_W'(v);    end
      default:    begin c.red = CH_W'(v);    c.green = CH_W'(lo);   c.blue = CH_W'(down); end
    endcase
    return c;
  endfunction

  task automatic add_pixel(input int h, input int s, input int v, input bit drain);
    pixel_t px;
    px.hue   = HUE_W'(h);
    px.sat   = CH_W'(s);
    px.bri   = CH_W'(v);
    px.drain = drain;
    pixel_queue.push_back(px);
  endtask

  function automatic int pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return CH_MAX;
    if (r < 20) return 1;
    return $urandom_range(0, CH_MAX);
  endfunction

  task automatic fill_pixels();
    int h, s, v, r;
    // corners: gray, hue wrap, sector edges, channel extremes
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(1000, 0, 255, 1'b0);
    add_pixel(65535, 0, 77, 1'b0);
    add_pixel(0, 255, 255, 1'b0);
    add_pixel(SECTOR_SIZE - 1, 255, 255, 1'b0);
    add_pixel(SECTOR_SIZE, 255, 255, 1'b0);
    add_pixel(2 * SECTOR_SIZE + 128, 200, 180, 1'b0);
    add_pixel(3 * SECTOR_SIZE + 17, 1, 255, 1'b0);
    add_pixel(4 * SECTOR_SIZE + 200, 128, 1, 1'b0);
    add_pixel(5 * SECTOR_SIZE + 64, 90, 240, 1'b0);
    add_pixel(HUE_LIMIT - 1, 255, 255, 1'b0);
    add_pixel(HUE_LIMIT, 255, 255, 1'b0);
    add_pixel(HUE_LIMIT + 300, 100, 200, 1'b0);
    add_pixel(65535, 255, 255, 1'b0);
    add_pixel(32768, 37, 150, 1'b0);
    add_pixel(SECTOR_SIZE / 2, 255, 0, 1'b0);
    add_pixel(SECTOR_SIZE + 1, 1, 1, 1'b0);
    add_pixel(3 * SECTOR_SIZE - 1, 254, 254, 1'b0);
    add_pixel(4 * SECTOR_SIZE, 170, 85, 1'b0);
    add_pixel(5 * SECTOR_SIZE, 255, 128, 1'b0);
    add_pixel(6 * SECTOR_SIZE - 1, 60, 255, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) h = $urandom_range(0, 65535);
      else if (r < 22) h = $urandom_range(0, 5) * SECTOR_SIZE + ($urandom_range(0, 1) ?
                             SECTOR_SIZE - 1 : 0);
      else h = $urandom_range(0, HUE_LIMIT - 1);
      s = ($urandom_range(0, 99) < 8) ? 0 : pick_channel();
      v = pick_channel();
      add_pixel(h, s, v, (i == NUM_RANDOM / 2) || ($urandom_range(0, 199) == 0));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    pixel_t px;
    if (!rst_ni) begin
      start   <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (start && !busy) rgb_expected.push_back(hsv_predict(cur_px));
      if (!(start && busy)) begin
        if (pixel_queue.size() == 0) begin
          start <= 1'b0;
        end else if (pixel_queue[0].drain && rgb_expected.size() != 0) begin
          start <= 1'b0;
        end else if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          start   <= 1'b0;
        end else begin
          px = pixel_queue.pop_front();
          cur_px       <= px;
          hue_i        <= px.hue;
          saturation_i <= px.sat;
          brightness_i <= px.bri;
          start        <= 1'b1;
          if ($urandom_range(0, 49) == 0) burst <= !burst;
          gap_cnt <= burst ? 0 : $urandom_range(0, 12);
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    rgb_t want;
    if (rst_ni && valid_o) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
      end else begin
        want = rgb_expected.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
        end
      end
    end
  end

  initial begin
    fill_pixels();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pixel_queue.size() != 0 || start || rgb_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("hsv_to_rgb_converter regression: pass");
    end else begin
      $display("hsv_to_rgb_converter regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("hsv_to_rgb_converter regression: fail");
    $finish;
  end

endmodule
